FILE: src/tta_pkg.sv
// Shared types, constants and the log2 table for the thermistor temperature averager.
// Used by tta_mul, tta_div and thermistor_temperature_averager_top.
`default_nettype none

package tta_pkg;

  localparam int CHANNEL_COUNT_DEF  = 9;
  localparam int ADC_FULL_SCALE_DEF = 1023;
  localparam int HOLD_MS_DEF        = 30000;
  localparam int NOMINAL_TEMP_C_DEF = 25;

  localparam int KELVIN_Q16 = 17901158;
  localparam int KELVIN_Q8  = 69926;
  localparam int LN2_Q16    = 45426;

  localparam int MUL_AW = 48;
  localparam int MUL_BW = 25;
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 32;

  localparam int AVG_DIVISOR = 20;
  localparam int AVG_BIAS    = 2621440;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_NORM,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    SP_LOG1,
    SP_INT1,
    SP_LOG2,
    SP_INT2,
    SP_LN,
    SP_DEN,
    SP_NUM,
    SP_TK,
    SP_AVG
  } step_e;

  typedef enum logic [2:0] {
    CFG_SERIES_A,
    CFG_NOMINAL_A,
    CFG_BETA_A,
    CFG_SERIES_B,
    CFG_NOMINAL_B,
    CFG_BETA_B,
    CFG_LOW_LIMIT,
    CFG_HIGH_LIMIT
  } cfg_idx_e;

  // log2(1 + k/16) in Q16.
  function automatic logic [16:0] log2_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      5'd16:   v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: src/tta_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on tta_pkg for the operand widths.
`default_nettype none

module tta_mul (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [tta_pkg::MUL_AW-1:0] a_i,
  input  wire logic [tta_pkg::MUL_BW-1:0] b_i,
  output logic                            done_o,
  output logic [tta_pkg::MUL_AW-1:0]      p_o
);

  logic                       run_q, run_d;
  logic [tta_pkg::MUL_AW-1:0] a_q, a_d, acc_q, acc_d;
  logic [tta_pkg::MUL_BW-1:0] b_q, b_d;

  always_comb begin
    run_d = run_q;
    a_d   = a_q;
    b_d   = b_q;
    acc_d = acc_q;
    if (start_i) begin
      run_d = 1'b1;
      a_d   = a_i;
      b_d   = b_i;
      acc_d = '0;
    end else if (run_q) begin
      if (b_q == '0) begin
        run_d = 1'b0;
      end else begin
        if (b_q[0]) begin
          acc_d = acc_q + a_q;
        end
        a_d = {a_q[tta_pkg::MUL_AW-2:0], 1'b0};
        b_d = {1'b0, b_q[tta_pkg::MUL_BW-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = run_q && (b_q == '0);
  assign p_o    = acc_q;

endmodule

`default_nettype wire

FILE: src/tta_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tta_pkg for the operand widths.
`default_nettype none

module tta_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [tta_pkg::DIV_NW-1:0] n_i,
  input  wire logic [tta_pkg::DIV_DW-1:0] d_i,
  output logic                            done_o,
  output logic [tta_pkg::DIV_NW-1:0]      q_o
);

  localparam int CW = $clog2(tta_pkg::DIV_NW + 1);

  logic                       run_q, run_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [tta_pkg::DIV_NW-1:0] n_q, n_d;
  logic [tta_pkg::DIV_DW-1:0] d_q, d_d, rem_q, rem_d;
  logic [tta_pkg::DIV_DW:0]   trial;
  logic                       ge;
  logic                       last;

  assign last  = (cnt_q == CW'(tta_pkg::DIV_NW));
  assign trial = {rem_q, n_q[tta_pkg::DIV_NW-1]};
  assign ge    = (trial >= {1'b0, d_q});

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    n_d   = n_q;
    d_d   = d_q;
    rem_d = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      n_d   = n_i;
      d_d   = d_i;
      rem_d = '0;
    end else if (run_q) begin
      if (last) begin
        run_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        rem_d = ge ? tta_pkg::DIV_DW'(trial - {1'b0, d_q}) : trial[tta_pkg::DIV_DW-1:0];
        n_d   = {n_q[tta_pkg::DIV_NW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    d_q   <= d_d;
    rem_q <= rem_d;
  end

  assign done_o = run_q && last;
  assign q_o    = n_q;

endmodule

`default_nettype wire

FILE: src/thermistor_temperature_averager_top.sv
// Top level of the thermistor temperature averager: sequencer, settings and channel state.
// Depends on tta_pkg, tta_mul and tta_div.
//
// Samples enter on the s_axis channel (channel, counts and time in tdata, sensor kind
// in tuser); one result per sample leaves on the m_axis channel. Settings are written
// through cfg_we_i, cfg_idx_i and cfg_data_i while no sample is in flight, a rule that the
// user must keep, since the block does not enforce it. A sample is converted to resistance
// products, two logarithms, the beta equation and a reciprocal, then folded into the
// channel's running average. All products run through one bit-serial multiplier and both
// divisions through one bit-serial divider; the normalizing shifts of the two logarithms,
// the constant products and the two 48-step divisions are most of the work, and a sample
// whose temperature is out of limits skips the second division. Samples that fail the
// early checks go from the start state straight to the done state, which registers their
// result. One sample is processed at a time; the next is taken once the previous one has
// been placed in the output register, which holds it while the receiver stalls.
// Reset restores the default settings, clears every channel average, presence flag and
// deadline, and empties the output register.
`default_nettype none

module thermistor_temperature_averager_top #(
  parameter int CHANNEL_COUNT  = tta_pkg::CHANNEL_COUNT_DEF,
  parameter int ADC_FULL_SCALE = tta_pkg::ADC_FULL_SCALE_DEF,
  parameter int HOLD_MS        = tta_pkg::HOLD_MS_DEF,
  parameter int NOMINAL_TEMP_C = tta_pkg::NOMINAL_TEMP_C_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // channel, adc_counts, now_ms
  input  wire logic [0:0]  s_axis_tuser,  // sensor_kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // out_channel, average_temp
  output logic [1:0]       m_axis_tuser,  // average_valid, sample_valid
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [19:0] cfg_data_i
);

  localparam int IDX_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int T0_Q16 = NOMINAL_TEMP_C * 65536 + tta_pkg::KELVIN_Q16;

  tta_pkg::state_e state_q, state_d;
  tta_pkg::step_e  step_q, step_d;

  logic [19:0] ser_a_q, nom_a_q, ser_b_q, nom_b_q;
  logic [13:0] beta_a_q, beta_b_q;
  logic signed [16:0] low_q, high_q;

  logic signed [16:0] avg_mem_q [CHANNEL_COUNT];
  logic               pres_q    [CHANNEL_COUNT];
  logic [31:0]        dead_q    [CHANNEL_COUNT];

  logic [3:0]  ch_q, ch_d;
  logic        kind_q, kind_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [31:0] now_q, now_d;
  logic [47:0] nrm_q, nrm_d;
  logic [5:0]  sh_q, sh_d;
  logic [21:0] l1_q, l1_d;
  logic        neg_q, neg_d;
  logic signed [33:0] den_q, den_d;
  logic        ok_q, ok_d;
  logic signed [16:0] navg_q, navg_d;

  logic        m_valid_q, m_valid_d;
  logic [23:0] m_data_q, m_data_d;
  logic [1:0]  m_user_q, m_user_d;

  logic                       mul_start, mul_done;
  logic [tta_pkg::MUL_AW-1:0] mul_a, mul_p;
  logic [tta_pkg::MUL_BW-1:0] mul_b;
  logic                       div_start, div_done;
  logic [tta_pkg::DIV_NW-1:0] div_n, div_q;
  logic [tta_pkg::DIV_DW-1:0] div_d;

  logic [19:0] rs, rn;
  logic [13:0] beta;
  logic [15:0] full_minus;
  logic        ch_ok, start_ok, out_free;
  logic [IDX_W-1:0] idx;

  logic [4:0]  tk;
  logic [16:0] tab_lo, tab_hi;
  logic [5:0]  e_cur;
  logic [16:0] val_cur;
  logic [21:0] l_cur;
  logic signed [22:0] d_cur;
  logic [22:0] d_abs;
  logic signed [48:0] mul_ps;
  logic signed [32:0] mul_sh;
  logic signed [22:0] ln_cur;
  logic [22:0] ln_abs;
  logic signed [33:0] den_cur;
  logic        den_pos;
  logic signed [48:0] t_cur;
  logic        t_ok;
  logic signed [16:0] seed;
  logic signed [24:0] avg_num;
  logic [31:0] late_diff;
  logic        late;
  logic        pres_new;
  logic signed [16:0] avg_new;

  assign rs   = kind_q ? ser_b_q : ser_a_q;
  assign rn   = kind_q ? nom_b_q : nom_a_q;
  assign beta = kind_q ? beta_b_q : beta_a_q;
  assign full_minus = 16'(ADC_FULL_SCALE) - {6'd0, cnt_q};
  assign ch_ok = ({1'b0, ch_q} < 5'(CHANNEL_COUNT));
  assign idx   = ch_q[IDX_W-1:0];
  assign start_ok = ch_ok && (cnt_q != '0) && ({6'd0, cnt_q} < 16'(ADC_FULL_SCALE)) &&
                    (rs != '0) && (rn != '0) && (beta != '0);
  assign out_free = !m_valid_q || m_axis_tready;

  // Logarithm of the normalized product: exponent plus interpolated table value.
  assign tk      = {1'b0, nrm_q[46:43]};
  assign tab_lo  = tta_pkg::log2_tab(tk);
  assign tab_hi  = tta_pkg::log2_tab(tk + 5'd1);
  assign e_cur   = 6'd47 - sh_q;
  assign val_cur = tab_lo + {1'b0, mul_p[31:16]};
  assign l_cur   = {e_cur, 16'd0} + {5'd0, val_cur};
  assign d_cur   = $signed({1'b0, l1_q}) - $signed({1'b0, l_cur});
  assign d_abs   = d_cur[22] ? 23'(-d_cur) : d_cur;

  assign mul_ps  = neg_q ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
  assign mul_sh  = 33'(mul_ps >>> 16);
  assign ln_cur  = mul_sh[22:0];
  assign ln_abs  = ln_cur[22] ? 23'(-ln_cur) : ln_cur;
  assign den_cur = $signed({4'd0, beta, 16'd0}) + 34'(mul_sh);
  assign den_pos = !den_cur[33] && (den_cur != '0);

  assign t_cur = $signed({1'b0, div_q}) - 49'sd69926;
  assign t_ok  = (t_cur >= 49'(low_q)) && (t_cur <= 49'(high_q));

  assign seed    = pres_q[idx] ? avg_mem_q[idx] : t_cur[16:0];
  assign avg_num = (25'(seed) <<< 4) + (25'(seed) <<< 1) + 25'(seed) + 25'(t_cur) +
                   25'sd10 + 25'(tta_pkg::AVG_BIAS);

  assign late_diff = now_q - dead_q[idx];
  assign late      = (late_diff != '0) && !late_diff[31];

  always_comb begin
    pres_new = 1'b0;
    avg_new  = '0;
    if (ch_ok) begin
      pres_new = pres_q[idx];
      avg_new  = avg_mem_q[idx];
      if (ok_q) begin
        pres_new = 1'b1;
        avg_new  = navg_q;
      end else if (late) begin
        pres_new = 1'b0;
        avg_new  = '0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      tta_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = tta_pkg::ST_START;
      end
      tta_pkg::ST_START: begin
        if (start_ok) begin
          state_d = tta_pkg::ST_MUL;
          step_d  = tta_pkg::SP_LOG1;
        end else begin
          state_d = tta_pkg::ST_DONE;
        end
      end
      tta_pkg::ST_MUL: begin
        if (mul_done) begin
          case (step_q)
            tta_pkg::SP_LOG1, tta_pkg::SP_LOG2: state_d = tta_pkg::ST_NORM;
            tta_pkg::SP_INT1: step_d = tta_pkg::SP_LOG2;
            tta_pkg::SP_INT2: step_d = tta_pkg::SP_LN;
            tta_pkg::SP_LN:   step_d = tta_pkg::SP_DEN;
            tta_pkg::SP_DEN: begin
              if (den_pos) step_d = tta_pkg::SP_NUM;
              else state_d = tta_pkg::ST_DONE;
            end
            tta_pkg::SP_NUM: begin
              state_d = tta_pkg::ST_DIV;
              step_d  = tta_pkg::SP_TK;
            end
            default: state_d = tta_pkg::ST_DONE;
          endcase
        end
      end
      tta_pkg::ST_NORM: begin
        if (nrm_q[47]) begin
          state_d = tta_pkg::ST_MUL;
          step_d  = (step_q == tta_pkg::SP_LOG1) ? tta_pkg::SP_INT1 : tta_pkg::SP_INT2;
        end
      end
      tta_pkg::ST_DIV: begin
        if (div_done) begin
          if (step_q == tta_pkg::SP_TK && t_ok) step_d = tta_pkg::SP_AVG;
          else state_d = tta_pkg::ST_DONE;
        end
      end
      tta_pkg::ST_DONE: begin
        if (out_free) state_d = tta_pkg::ST_IDLE;
      end
      default: state_d = tta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ch_d      = ch_q;
    kind_d    = kind_q;
    cnt_d     = cnt_q;
    now_d     = now_q;
    nrm_d     = nrm_q;
    sh_d      = sh_q;
    l1_d      = l1_q;
    neg_d     = neg_q;
    den_d     = den_q;
    ok_d      = ok_q;
    navg_d    = navg_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    unique case (state_q)
      tta_pkg::ST_IDLE: begin
        ch_d   = s_axis_tdata[3:0];
        cnt_d  = s_axis_tdata[13:4];
        now_d  = s_axis_tdata[45:14];
        kind_d = s_axis_tuser[0];
      end
      tta_pkg::ST_START: begin
        ok_d      = 1'b0;
        mul_start = start_ok;
        mul_a     = 48'(rs);
        mul_b     = 25'(cnt_q);
      end
      tta_pkg::ST_MUL: begin
        if (mul_done) begin
          case (step_q)
            tta_pkg::SP_LOG1, tta_pkg::SP_LOG2: begin
              nrm_d = mul_p;
              sh_d  = '0;
            end
            tta_pkg::SP_INT1: begin
              l1_d      = l_cur;
              mul_start = 1'b1;
              mul_a     = 48'(rn);
              mul_b     = 25'(full_minus);
            end
            tta_pkg::SP_INT2: begin
              neg_d     = d_cur[22];
              mul_start = 1'b1;
              mul_a     = 48'(d_abs);
              mul_b     = 25'(tta_pkg::LN2_Q16);
            end
            tta_pkg::SP_LN: begin
              neg_d     = ln_cur[22];
              mul_start = 1'b1;
              mul_a     = 48'(ln_abs);
              mul_b     = 25'(T0_Q16);
            end
            tta_pkg::SP_DEN: begin
              den_d     = den_cur;
              mul_start = den_pos;
              mul_a     = 48'(beta);
              mul_b     = 25'(T0_Q16);
            end
            tta_pkg::SP_NUM: begin
              div_start = 1'b1;
              div_n     = {mul_p[39:0], 8'd0} + {17'd0, den_q[31:1]};
              div_d     = den_q[31:0];
            end
            default: ;
          endcase
        end
      end
      tta_pkg::ST_NORM: begin
        if (nrm_q[47]) begin
          mul_start = 1'b1;
          mul_a     = 48'(tab_hi - tab_lo);
          mul_b     = 25'(nrm_q[42:27]);
        end else begin
          nrm_d = {nrm_q[46:0], 1'b0};
          sh_d  = sh_q + 1'b1;
        end
      end
      tta_pkg::ST_DIV: begin
        if (div_done) begin
          if (step_q == tta_pkg::SP_TK) begin
            if (t_ok) begin
              ok_d      = 1'b1;
              div_start = 1'b1;
              div_n     = 48'(avg_num[23:0]);
              div_d     = 32'(tta_pkg::AVG_DIVISOR);
            end
          end else begin
            navg_d = div_q[16:0];
          end
        end
      end
      tta_pkg::ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {3'd0, (pres_new ? avg_new : 17'sd0), ch_q};
          m_user_d  = {ok_q, pres_new};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tta_pkg::ST_IDLE;
      step_q    <= tta_pkg::SP_LOG1;
      ok_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      ok_q      <= ok_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q     <= ch_d;
    kind_q   <= kind_d;
    cnt_q    <= cnt_d;
    now_q    <= now_d;
    nrm_q    <= nrm_d;
    sh_q     <= sh_d;
    l1_q     <= l1_d;
    neg_q    <= neg_d;
    den_q    <= den_d;
    navg_q   <= navg_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_a_q  <= 20'd10000;
      nom_a_q  <= 20'd10000;
      beta_a_q <= 14'd3950;
      ser_b_q  <= 20'd10000;
      nom_b_q  <= 20'd10000;
      beta_b_q <= 14'd3950;
      low_q    <= -17'sd10240;
      high_q   <= 17'sd25600;
    end else if (cfg_we_i) begin
      unique case (tta_pkg::cfg_idx_e'(cfg_idx_i))
        tta_pkg::CFG_SERIES_A:   ser_a_q  <= cfg_data_i;
        tta_pkg::CFG_NOMINAL_A:  nom_a_q  <= cfg_data_i;
        tta_pkg::CFG_BETA_A:     beta_a_q <= cfg_data_i[13:0];
        tta_pkg::CFG_SERIES_B:   ser_b_q  <= cfg_data_i;
        tta_pkg::CFG_NOMINAL_B:  nom_b_q  <= cfg_data_i;
        tta_pkg::CFG_BETA_B:     beta_b_q <= cfg_data_i[13:0];
        tta_pkg::CFG_LOW_LIMIT:  low_q    <= cfg_data_i[16:0];
        tta_pkg::CFG_HIGH_LIMIT: high_q   <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        avg_mem_q[i] <= '0;
        pres_q[i]    <= 1'b0;
        dead_q[i]    <= '0;
      end
    end else if (state_q == tta_pkg::ST_DONE && out_free && ch_ok) begin
      avg_mem_q[idx] <= avg_new;
      pres_q[idx]    <= pres_new;
      if (ok_q) begin
        dead_q[idx] <= now_q + 32'(HOLD_MS);
      end
    end
  end

  tta_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  tta_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .n_i    (div_n),
    .d_i    (div_d),
    .done_o (div_done),
    .q_o    (div_q)
  );

  assign s_axis_tready = (state_q == tta_pkg::ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

FILE: verif/tb_thermistor_temperature_averager_top.sv
// Self-checking testbench for thermistor_temperature_averager_top: directed and random samples
// over several register settings, checked against an internal beta-equation averager model.
// Depends on tta_pkg and the RTL of the block only.
`default_nettype none

module tb_thermistor_temperature_averager_top;

  typedef struct {
    logic [3:0]  ch;
    logic        kind;
    logic [9:0]  counts;
    logic [31:0] now;
  } sample_t;

  typedef struct {
    logic [3:0]  ch;
    logic [16:0] temp;
    logic        avg_ok;
    logic        smp_ok;
  } report_t;

  localparam longint LG_TAB[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
                                    42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // channel, adc_counts, now_ms
  logic [0:0]  s_axis_tuser;   // sensor_kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // out_channel, average_temp
  logic [1:0]  m_axis_tuser;   // average_valid, sample_valid
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [19:0] cfg_data_i;

  thermistor_temperature_averager_top dut (.*);

  longint series_ohms[2], nominal_ohms[2], beta_k[2], low_lim, high_lim;
  longint chan_avg[9];
  bit     avg_present[9];
  logic [31:0] deadline[9];

  sample_t sample_q[$];
  report_t temp_expect_q[$];
  sample_t cur;
  int unsigned cyc, idle_cyc, n_sent, n_recv, n_err, n_valid_smp;
  logic [31:0] now_t;

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  function automatic longint log2_q16(longint unsigned v);
    int e;
    longint unsigned m, f, k, w;
    e = 0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    if (e >= 31) m = v >> (e - 31);
    else m = v << (31 - e);
    f = m & 64'h7FFF_FFFF;
    k = f >> 27;
    w = (f >> 11) & 64'hFFFF;
    return longint'(e) * 65536 + LG_TAB[k] + (((LG_TAB[k + 1] - LG_TAB[k]) * w) >>> 16);
  endfunction

  function automatic report_t convert_and_average(sample_t s);
    report_t r;
    longint rs, rn, bt, c, d, dl, t0, den, num, t, a, x, q;
    logic [31:0] diff;
    bit ok;
    r = '{s.ch, 17'd0, 1'b0, 1'b0};
    if (s.ch >= 9) return r;
    rs = series_ohms[s.kind];
    rn = nominal_ohms[s.kind];
    bt = beta_k[s.kind];
    c = s.counts;
    ok = 0;
    t = 0;
    if (c != 0 && c < 1023 && rs != 0 && rn != 0 && bt != 0) begin
      d = log2_q16(rs * c) - log2_q16(rn * (1023 - c));
      dl = (d * tta_pkg::LN2_Q16) >>> 16;
      t0 = longint'(tta_pkg::NOMINAL_TEMP_C_DEF) * 65536 + tta_pkg::KELVIN_Q16;
      den = bt * 65536 + ((dl * t0) >>> 16);
      if (den > 0) begin
        num = bt * t0 * 256;
        t = (num + den / 2) / den - tta_pkg::KELVIN_Q8;
        ok = (t >= low_lim && t <= high_lim);
      end
    end
    if (ok) begin
      a = avg_present[s.ch] ? chan_avg[s.ch] : t;
      x = 19 * a + t + 10;
      q = x / 20;
      if (x % 20 != 0 && x < 0) q--;
      chan_avg[s.ch] = q;
      avg_present[s.ch] = 1;
      deadline[s.ch] = s.now + tta_pkg::HOLD_MS_DEF;
    end else begin
      diff = s.now - deadline[s.ch];
      if (diff != 0 && diff < 32'h8000_0000) begin
        avg_present[s.ch] = 0;
        chan_avg[s.ch] = 0;
      end
    end
    if (avg_present[s.ch]) begin
      r.temp = chan_avg[s.ch][16:0];
      r.avg_ok = 1'b1;
    end
    r.smp_ok = ok;
    return r;
  endfunction

  // Transfer driver: the next sample is presented once the current one has gone, with random idle gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        temp_expect_q.push_back(convert_and_average(cur));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_q.size() > 0 && !(idle_cyc == 0 && $urandom_range(99) < 6)) begin
          cur = sample_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {2'b00, cur.now, cur.counts, cur.ch};
          s_axis_tuser <= cur.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    report_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_recv++;
        if (temp_expect_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result tdata=%h tuser=%b", m_axis_tdata,
                                    m_axis_tuser);
        end else begin
          e = temp_expect_q.pop_front();
          if (m_axis_tuser[1]) n_valid_smp++;
          if (m_axis_tdata[3:0] !== e.ch || m_axis_tdata[20:4] !== e.temp ||
              m_axis_tdata[23:21] !== 3'b000 ||
              m_axis_tuser[0] !== e.avg_ok || m_axis_tuser[1] !== e.smp_ok) begin
            n_err++;
            if (n_err <= 10)
              $display({"result %0d: expected ch=%0d temp=%0d avg_ok=%b smp_ok=%b, ",
                        "got ch=%0d temp=%0d avg_ok=%b smp_ok=%b"},
                       n_recv, e.ch, $signed(e.temp), e.avg_ok, e.smp_ok, m_axis_tdata[3:0],
                       $signed(m_axis_tdata[20:4]), m_axis_tuser[0], m_axis_tuser[1]);
          end
        end
      end
      m_axis_tready <= (idle_cyc != 0) || ($urandom_range(99) >= 6);
    end
  end

  // A stretch without any idling on either side, then a watchdog on transfers.
  int unsigned quiet_cnt;
  always @(posedge clk_i) begin
    cyc++;
    idle_cyc <= (cyc >= 20000 && cyc < 40000) ? 1 : 0;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i ||
        (sample_q.size() == 0 && !s_axis_tvalid && temp_expect_q.size() == 0))
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", temp_expect_q.size());
      $display("thermistor_temperature_averager_top: mismatch");
      $finish;
    end
  end

  task automatic cfg_write(tta_pkg::cfg_idx_e idx, longint val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[19:0];
    case (idx)
      tta_pkg::CFG_SERIES_A:   series_ohms[0] = val & 20'hFFFFF;
      tta_pkg::CFG_NOMINAL_A:  nominal_ohms[0] = val & 20'hFFFFF;
      tta_pkg::CFG_BETA_A:     beta_k[0] = val & 14'h3FFF;
      tta_pkg::CFG_SERIES_B:   series_ohms[1] = val & 20'hFFFFF;
      tta_pkg::CFG_NOMINAL_B:  nominal_ohms[1] = val & 20'hFFFFF;
      tta_pkg::CFG_BETA_B:     beta_k[1] = val & 14'h3FFF;
      tta_pkg::CFG_LOW_LIMIT:  low_lim = longint'($signed(val[16:0]));
      tta_pkg::CFG_HIGH_LIMIT: high_lim = longint'($signed(val[16:0]));
      default: ;
    endcase
  endtask

  task automatic cfg_all(longint sa, longint na, longint ba, longint sb, longint nb,
                         longint bb, longint lo, longint hi);
    cfg_write(tta_pkg::CFG_SERIES_A, sa);
    cfg_write(tta_pkg::CFG_NOMINAL_A, na);
    cfg_write(tta_pkg::CFG_BETA_A, ba);
    cfg_write(tta_pkg::CFG_SERIES_B, sb);
    cfg_write(tta_pkg::CFG_NOMINAL_B, nb);
    cfg_write(tta_pkg::CFG_BETA_B, bb);
    cfg_write(tta_pkg::CFG_LOW_LIMIT, lo);
    cfg_write(tta_pkg::CFG_HIGH_LIMIT, hi);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (!(sample_q.size() == 0 && !s_axis_tvalid && temp_expect_q.size() == 0))
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push(int ch, int kind, int counts, logic [31:0] now);
    sample_t s;
    s = '{ch[3:0], kind[0], counts[9:0], now};
    sample_q.push_back(s);
  endtask

  task automatic push_random(int n);
    int ch, k, p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 3) now_t = $urandom;
      else if (p < 13) now_t += $urandom_range(40000, 29990);
      else now_t += $urandom_range(2000);
      ch = ($urandom_range(99) < 8) ? $urandom_range(15, 9) : $urandom_range(8);
      p = $urandom_range(99);
      if (p < 5) k = 0;
      else if (p < 10) k = 1023;
      else if (p < 25) k = $urandom_range(1023);
      else k = $urandom_range(1000, 20);
      push(ch, $urandom_range(1), k, now_t);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    cyc = 0; idle_cyc = 0; quiet_cnt = 0;
    n_sent = 0; n_recv = 0; n_err = 0; n_valid_smp = 0;
    series_ohms = '{10000, 10000};
    nominal_ohms = '{10000, 10000};
    beta_k = '{3950, 3950};
    low_lim = -10240;
    high_lim = 25600;
    foreach (chan_avg[i]) begin
      chan_avg[i] = 0;
      avg_present[i] = 0;
      deadline[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Rails, both kinds, unused channels, time wrap and the deadline boundary.
    push(0, 0, 512, 32'd1000);
    push(0, 0, 0, 32'd31000);
    push(0, 1, 1023, 32'd31001);
    push(1, 1, 1, 32'd0);
    push(1, 0, 1022, 32'd5);
    push(2, 1, 300, 32'hFFFF_FFFF);
    push(2, 0, 0, 32'd29998);
    push(8, 0, 700, 32'd10);
    push(9, 1, 512, 32'd10);
    push(15, 0, 512, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) push(3, i & 1, 400 + 20 * i, 32'd100 * i);
    drain();

    cfg_all(1, 1000000, 10000, 1000000, 1, 1, -65536, 65535);
    push(0, 0, 1, 32'd0);
    push(0, 0, 1022, 32'd1);
    push(1, 1, 1, 32'd2);
    push(1, 1, 1022, 32'd3);
    push_random(110);
    drain();

    cfg_all(0, 10000, 3950, 10000, 0, 3950, 0, 6400);
    push(4, 0, 512, now_t);
    push(4, 1, 512, now_t);
    push_random(110);
    drain();

    cfg_all(0, 0, 0, 0, 0, 0, 0, 0);
    cfg_all(4700, 10000, 3435, 100000, 47000, 4250, -2560, 12800);
    push_random(130);
    drain();

    cfg_all(10000, 10000, 3950, 10000, 10000, 3950, 65535, -65536);
    push_random(60);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      cfg_all($urandom_range(1000000, 1), $urandom_range(1000000, 1),
              $urandom_range(10000, 1), $urandom_range(1000000, 1),
              $urandom_range(1000000, 1), $urandom_range(10000, 1),
              -longint'($urandom_range(20000)), longint'($urandom_range(40000)));
      push_random(110);
      drain();
    end

    repeat (400) @(posedge clk_i);
    $display("%0d samples sent and %0d results checked over eight register settings,",
             n_sent, n_recv);
    $display("%0d samples were in limits; %0d mismatches.", n_valid_smp, n_err);
    if (n_err == 0 && temp_expect_q.size() == 0) begin
      $display("thermistor_temperature_averager_top: match");
    end else begin
      $display("thermistor_temperature_averager_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
src/tta_pkg.sv
src/tta_mul.sv
src/tta_div.sv
src/thermistor_temperature_averager_top.sv
verif/tb_thermistor_temperature_averager_top.sv
